### rtl/core/ksta_pkg.sv
// Shared types, request codes and status codes for the keyed slot table allocator.
`default_nettype none

package ksta_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int REQ_W = 2;
  localparam int KEY_W = 31;
  localparam int SIDX_W = 4;
  localparam int STAT_W = 3;
  localparam int CNT_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_FIND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GRAB = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_FOUND = 3'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  key;
    logic [SIDX_W-1:0] slot_index;
  } req_t;

endpackage

`default_nettype wire

### rtl/core/keyed_slot_table_allocator.sv
// Keyed slot table allocator: a chain of slot cells scanned by a travelling token.
// The token passes each cell's register in turn; the decision then registers out_strobe.
// One request is in the chain at a time; the token steps one cell per cycle.
// The next request may be accepted in the same cycle its predecessor's result shows.
// Reset (rst_n low, synchronous): every slot empty, high-water count zero, idle.
// Results go out for one cycle on out_strobe; the receiver cannot stall them.
`default_nettype none

module keyed_slot_table_allocator #(
  parameter int SLOTS = ksta_pkg::SLOTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire [ksta_pkg::REQ_W-1:0]       in_req_type,
  input  wire [ksta_pkg::KEY_W-1:0]       in_key,
  input  wire [ksta_pkg::SIDX_W-1:0]      in_slot_index,
  output logic                            out_strobe,
  output logic [ksta_pkg::STAT_W-1:0]     out_status,
  output logic [ksta_pkg::SIDX_W-1:0]     out_result_slot,
  output logic [ksta_pkg::CNT_W-1:0]      out_used_count
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW_W  = $clog2(SLOTS+1);
  // widened views so outputs can be masked to port width at any SLOTS
  localparam int SW    = (IDX_W > ksta_pkg::SIDX_W) ? IDX_W : ksta_pkg::SIDX_W;
  localparam int CW    = (HW_W > ksta_pkg::CNT_W) ? HW_W : ksta_pkg::CNT_W;
  localparam logic [HW_W-1:0] HW_FULL = HW_W'(SLOTS);

  // token chain: entry 0 feeds cell 0, entry SLOTS is the tail
  logic             valid_c   [SLOTS+1];
  ksta_pkg::req_t   req_c     [SLOTS+1];
  logic             hit_v_c   [SLOTS+1];
  logic [IDX_W-1:0] hit_idx_c [SLOTS+1];
  logic             emp_v_c   [SLOTS+1];
  logic [IDX_W-1:0] emp_idx_c [SLOTS+1];
  logic [HW_W-1:0]  top_c     [SLOTS+1];

  logic             busy_r, busy_nxt;
  logic [HW_W-1:0]  hw_r, hw_nxt;
  logic             accept;

  // write-back issued in the decision cycle
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_idx;

  // decision results
  logic                       strobe_r;
  logic [ksta_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [SW-1:0]              slot_r, slot_nxt;

  ksta_pkg::req_t tail_req;
  logic           done;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // launch: the accepted request enters cell 0 with a clean token
  assign valid_c[0]   = accept;
  assign req_c[0]     = '{req_type: in_req_type, key: in_key, slot_index: in_slot_index};
  assign hit_v_c[0]   = 1'b0;
  assign hit_idx_c[0] = '0;
  assign emp_v_c[0]   = 1'b0;
  assign emp_idx_c[0] = '0;
  assign top_c[0]     = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ksta_cell #(
      .SLOTS    (SLOTS),
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .hw_i      (hw_r),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_key_i  (tail_req.key),
      .valid_i   (valid_c[g]),
      .req_i     (req_c[g]),
      .hit_v_i   (hit_v_c[g]),
      .hit_idx_i (hit_idx_c[g]),
      .emp_v_i   (emp_v_c[g]),
      .emp_idx_i (emp_idx_c[g]),
      .top_i     (top_c[g]),
      .valid_o   (valid_c[g+1]),
      .req_o     (req_c[g+1]),
      .hit_v_o   (hit_v_c[g+1]),
      .hit_idx_o (hit_idx_c[g+1]),
      .emp_v_o   (emp_v_c[g+1]),
      .emp_idx_o (emp_idx_c[g+1]),
      .top_o     (top_c[g+1])
    );
  end

  assign tail_req = req_c[SLOTS];
  assign done     = valid_c[SLOTS];

  // Decision on the token leaving the last cell. Free requests already
  // cleared their slot in passing; top_c holds the trimmed count.
  always_comb begin
    status_nxt = ksta_pkg::ST_MISS;
    slot_nxt   = '0;
    hw_nxt     = hw_r;
    wr_en      = 1'b0;
    wr_idx     = '0;
    busy_nxt   = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (done) begin
      busy_nxt = 1'b0;
      case (tail_req.req_type)
        ksta_pkg::REQ_FIND, ksta_pkg::REQ_GRAB: begin
          if (tail_req.key == '0) begin
            status_nxt = ksta_pkg::ST_MISS;
          end else if (hit_v_c[SLOTS]) begin
            status_nxt = ksta_pkg::ST_FOUND;
            slot_nxt   = SW'(hit_idx_c[SLOTS]);
          end else if (tail_req.req_type == ksta_pkg::REQ_FIND) begin
            status_nxt = ksta_pkg::ST_MISS;
          end else if (emp_v_c[SLOTS]) begin
            // reuse a hole below the high-water mark
            status_nxt = ksta_pkg::ST_ALLOC;
            slot_nxt   = SW'(emp_idx_c[SLOTS]);
            wr_en      = 1'b1;
            wr_idx     = emp_idx_c[SLOTS];
          end else if (hw_r == HW_FULL) begin
            status_nxt = ksta_pkg::ST_FULL;
          end else begin
            // extend the high-water mark
            status_nxt = ksta_pkg::ST_ALLOC;
            slot_nxt   = SW'(hw_r);
            wr_en      = 1'b1;
            wr_idx     = IDX_W'(hw_r);
            hw_nxt     = hw_r + 1'b1;
          end
        end
        ksta_pkg::REQ_FREE: begin
          if (32'(tail_req.slot_index) < SLOTS) begin
            status_nxt = ksta_pkg::ST_FREED;
            slot_nxt   = SW'(tail_req.slot_index);
            hw_nxt     = top_c[SLOTS];
          end else begin
            status_nxt = ksta_pkg::ST_MISS;
          end
        end
        default: begin
          status_nxt = ksta_pkg::ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      hw_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      hw_r     <= hw_nxt;
      strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  // count after the write-back, masked to port width
  logic [CW-1:0] hw_wide;
  assign hw_wide = CW'(hw_r);

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_result_slot = slot_r[ksta_pkg::SIDX_W-1:0];
  assign out_used_count  = hw_wide[ksta_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

### rtl/core/ksta_cell.sv
// One slot cell: holds a key and updates the scan token as it passes by.
`default_nettype none

module ksta_cell #(
  parameter int SLOTS    = ksta_pkg::SLOTS_DEF,
  parameter int CELL_IDX = 0
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // broadcast
  input  wire [$clog2(SLOTS+1)-1:0]      hw_i,
  input  wire                            wr_en_i,
  input  wire [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_idx_i,
  input  wire [ksta_pkg::KEY_W-1:0]      wr_key_i,
  // token in
  input  wire                            valid_i,
  input  wire ksta_pkg::req_t            req_i,
  input  wire                            hit_v_i,
  input  wire [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx_i,
  input  wire                            emp_v_i,
  input  wire [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] emp_idx_i,
  input  wire [$clog2(SLOTS+1)-1:0]      top_i,
  // token out
  output logic                           valid_o,
  output ksta_pkg::req_t                 req_o,
  output logic                           hit_v_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx_o,
  output logic                           emp_v_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] emp_idx_o,
  output logic [$clog2(SLOTS+1)-1:0]     top_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW_W  = $clog2(SLOTS+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [HW_W-1:0]  MY_HW  = HW_W'(CELL_IDX);
  localparam logic [HW_W-1:0]  MY_TOP = HW_W'(CELL_IDX + 1);

  logic [ksta_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                       valid_r;
  ksta_pkg::req_t             req_r;
  logic                       hit_v_r, emp_v_r;
  logic [IDX_W-1:0]           hit_idx_r, emp_idx_r;
  logic [HW_W-1:0]            top_r;

  logic active, mine, is_free, hit, emp, keep;

  assign active  = (MY_HW < hw_i);
  assign mine    = (32'(req_i.slot_index) == CELL_IDX);
  assign is_free = (req_i.req_type == ksta_pkg::REQ_FREE);
  assign hit     = active && (key_r == req_i.key) && !hit_v_i;
  assign emp     = active && (key_r == '0) && !emp_v_i;
  // slot stays occupied after this request
  assign keep    = (key_r != '0) && !(is_free && mine);

  always_comb begin
    key_nxt = key_r;
    if (valid_i && is_free && mine) begin
      key_nxt = '0;
    end else if (wr_en_i && (wr_idx_i == MY_IDX)) begin
      key_nxt = wr_key_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      key_r   <= key_nxt;
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_i;
    hit_v_r   <= hit_v_i | hit;
    hit_idx_r <= hit ? MY_IDX : hit_idx_i;
    emp_v_r   <= emp_v_i | emp;
    emp_idx_r <= emp ? MY_IDX : emp_idx_i;
    top_r     <= keep ? MY_TOP : top_i;
  end

  assign valid_o   = valid_r;
  assign req_o     = req_r;
  assign hit_v_o   = hit_v_r;
  assign hit_idx_o = hit_idx_r;
  assign emp_v_o   = emp_v_r;
  assign emp_idx_o = emp_idx_r;
  assign top_o     = top_r;

endmodule

`default_nettype wire

### tb/keyed_slot_table_allocator_checker.sv
// Transfer monitor, slot table predictor and result scoreboard for keyed_slot_table_allocator.
`default_nettype none

module keyed_slot_table_allocator_checker #(
  parameter int SLOTS = ksta_pkg::SLOTS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire                         busy,
  input  wire [ksta_pkg::REQ_W-1:0]   in_req_type,
  input  wire [ksta_pkg::KEY_W-1:0]   in_key,
  input  wire [ksta_pkg::SIDX_W-1:0]  in_slot_index,
  input  wire                         out_strobe,
  input  wire [ksta_pkg::STAT_W-1:0]  out_status,
  input  wire [ksta_pkg::SIDX_W-1:0]  out_result_slot,
  input  wire [ksta_pkg::CNT_W-1:0]   out_used_count,
  output int                          mismatches,
  output int                          outstanding
);
  import ksta_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIDX_W-1:0] slot;
    logic [CNT_W-1:0]  used;
  } alloc_result_t;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_keys [SLOTS];
  int               shadow_used;

  alloc_result_t    expected_results [$];
  alloc_result_t    want;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to the shadow table and returns the result it should give.
  function automatic alloc_result_t predict_table_step(input logic [REQ_W-1:0] req,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [SIDX_W-1:0] idx);
    alloc_result_t res;
    int hit;
    int hole;
    res.status = ST_MISS;
    res.slot = '0;
    hit = -1;
    hole = -1;
    if ((req == REQ_FIND || req == REQ_GRAB) && key != '0) begin
      for (int i = 0; i < shadow_used; i++) begin
        if (hit < 0 && shadow_keys[i] == key) hit = i;
        if (hole < 0 && shadow_keys[i] == '0) hole = i;
      end
      if (hit >= 0) begin
        res.status = ST_FOUND;
        res.slot = hit[SIDX_W-1:0];
      end else if (req == REQ_GRAB) begin
        if (hole >= 0) begin
          shadow_keys[hole] = key;
          res.status = ST_ALLOC;
          res.slot = hole[SIDX_W-1:0];
        end else if (shadow_used < SLOTS) begin
          shadow_keys[shadow_used] = key;
          res.status = ST_ALLOC;
          res.slot = shadow_used[SIDX_W-1:0];
          shadow_used++;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else if (req == REQ_FREE && int'(idx) < SLOTS) begin
      shadow_keys[idx] = '0;
      // trim trailing empties off the high-water count
      while (shadow_used > 0 && shadow_keys[shadow_used-1] == '0) shadow_used--;
      res.status = ST_FREED;
      res.slot = idx;
    end
    res.used = shadow_used[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) shadow_keys[i] = '0;
      shadow_used = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      // retire the oldest expectation before queuing a request accepted at this edge
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result status=%0d slot=%0d used=%0d with none expected",
                                    out_status, out_result_slot, out_used_count));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_result_slot !== want.slot)
            report_mismatch($sformatf("result_slot %0d, expected %0d",
                                      out_result_slot, want.slot));
          if (out_used_count !== want.used)
            report_mismatch($sformatf("used_count %0d, expected %0d",
                                      out_used_count, want.used));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_table_step(in_req_type, in_key, in_slot_index));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

### tb/keyed_slot_table_allocator_tb.sv
// Top testbench for keyed_slot_table_allocator: clock, reset, request stimulus and verdict.
`default_nettype none

// Stimulus outline:
//  - directed requests walk the table through its corner cases: find on an empty
//    table, key zero on find and grab, extreme keys, a repeated grab, a free above
//    the count, the unused request code, filling all slots, a grab on a full
//    table, reuse of a hole and trimming of the count.
//  - random requests in blocks of 100; each block leans toward filling, draining
//    or a mix, so the table swings between empty and full many times. Keys come
//    mostly from a small pool so finds and grabs hit, with some fresh full-range
//    keys and some key zero.
//  - the sender draws a random idle gap up to gap_max before each request; some blocks run
//    back to back so a new request lands on the cycle the previous result shows.
// The checker beside the block does all prediction and comparison.
module keyed_slot_table_allocator_tb;
  import ksta_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int POOL_SIZE = 24;          // more keys than slots, so the table fills
  localparam int RANDOM_ITEMS = 1250;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [KEY_W-1:0]   in_key = '0;
  logic [SIDX_W-1:0]  in_slot_index = '0;
  logic               busy;
  logic               out_strobe;
  logic [STAT_W-1:0]  out_status;
  logic [SIDX_W-1:0]  out_result_slot;
  logic [CNT_W-1:0]   out_used_count;
  int                 mismatches;
  int                 outstanding;

  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_slot_table_allocator #(.SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_key(in_key),
    .in_slot_index(in_slot_index),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_result_slot(out_result_slot),
    .out_used_count(out_used_count)
  );

  keyed_slot_table_allocator_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_key(in_key),
    .in_slot_index(in_slot_index),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_result_slot(out_result_slot),
    .out_used_count(out_used_count),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // One request transfer. Called at a rising edge; returns at the edge that took it.
  // With gap zero start stays high, so back-to-back requests need no extra edge.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic [SIDX_W-1:0] idx, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_key <= key;
    in_slot_index <= idx;
    // busy is sampled before this edge's updates land
    do @(posedge clk); while (busy);
  endtask

  // hard stop; well above the slowest legal run
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int grab_pct;
    int free_pct;
    int find_pct;
    int pick;
    int gap_max;
    logic [REQ_W-1:0]  req;
    logic [KEY_W-1:0]  key;

    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (key_pool[i] == '0) key_pool[i] = KEY_W'(i + 1);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send_request(REQ_FIND, 31'd1, '0, 0);                  // miss on empty table
    send_request(REQ_FIND, '0, '0, 1);                     // key zero on find
    send_request(REQ_GRAB, '0, 4'd9, 0);                   // key zero on grab
    send_request(REQ_GRAB, 31'h7FFF_FFFF, '0, 2);          // largest key, slot 0
    send_request(REQ_GRAB, 31'd1, 4'hF, 0);                // smallest key, slot 1
    send_request(REQ_GRAB, 31'd1, '0, 0);                  // already held: found
    send_request(REQ_FIND, 31'h7FFF_FFFF, '0, 3);          // find hit
    send_request(REQ_FREE, 31'h7FFF_FFFF, 4'hF, 0);        // free above the count
    send_request(REQ_UNUSED, 31'd1, 4'd5, 0);              // unused request code
    for (int s = 2; s < SLOTS; s++) begin
      send_request(REQ_GRAB, KEY_W'(s), 4'(s), s % 3);     // fill to the top
    end
    send_request(REQ_GRAB, 31'h5555_5555, '0, 0);          // full table
    send_request(REQ_FREE, '0, 4'd7, 0);                   // hole in the middle
    send_request(REQ_GRAB, 31'h2AAA_AAAA, '0, 0);          // reuses the hole
    send_request(REQ_FREE, '0, 4'd14, 0);                  // below the top, no trim
    send_request(REQ_FREE, '0, 4'd15, 0);                  // trims two slots

    // random part: per block a bias and an idling style
    grab_pct = 40;
    free_pct = 25;
    gap_max = 19;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin grab_pct = 60; free_pct = 15; end     // fill
          1: begin grab_pct = 20; free_pct = 55; end     // drain
          default: begin grab_pct = 40; free_pct = 30; end
        endcase
        gap_max = ($urandom_range(0, 9) < 4) ? 0 : 19;
      end
      find_pct = 95 - grab_pct - free_pct;                // about 5% unused code
      pick = $urandom_range(0, 99);
      if (pick < grab_pct) req = REQ_GRAB;
      else if (pick < grab_pct + free_pct) req = REQ_FREE;
      else if (pick < grab_pct + free_pct + find_pct) req = REQ_FIND;
      else req = REQ_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 97) key = KEY_W'($urandom);
      else key = '0;
      send_request(req, key, SIDX_W'($urandom_range(0, SLOTS - 1)),
                   $urandom_range(0, gap_max));
    end
    start <= 1'b0;

    // drain: outstanding is a registered copy of the checker's queue size
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/ksta_pkg.sv
rtl/core/ksta_cell.sv
rtl/core/keyed_slot_table_allocator.sv
tb/keyed_slot_table_allocator_checker.sv
tb/keyed_slot_table_allocator_tb.sv
